[rtl/frms_pkg.sv]
package frms_pkg;

   localparam int CFG_WIDTH = 16;
   localparam int STEPS_WIDTH = 6;
   localparam int TIMER_WIDTH_DEFAULT = 16;

   localparam logic [CFG_WIDTH-1:0] POWER_CYCLE_RESET = 16'd3000;
   localparam logic [CFG_WIDTH-1:0] SETTLE_RESET = 16'd100;
   localparam logic [CFG_WIDTH-1:0] PRESPIN_RESET = 16'd1500;
   localparam logic [STEPS_WIDTH-1:0] RAMP_STEPS_RESET = 6'd40;

   // longest run of zero-length waits that one beat can walk through
   localparam int ZERO_WAIT_CHAIN = 5;

   typedef enum logic [1:0] {
      CSR_POWER_CYCLE = 2'd0,
      CSR_SETTLE = 2'd1,
      CSR_PRESPIN = 2'd2,
      CSR_RAMP_STEPS = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_OFF = 2'd0,
      MODE_LOW = 2'd1,
      MODE_MID = 2'd2,
      MODE_HIGH = 2'd3
   } mode_type;

   typedef enum logic [6:0] {
      PH_IDLE = 7'b0000001,
      PH_CYCLE = 7'b0000010,
      PH_SETTLE = 7'b0000100,
      PH_PRESPIN = 7'b0001000,
      PH_SETTLE2 = 7'b0010000,
      PH_RAMP_ON = 7'b0100000,
      PH_RAMP_OFF = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic ext;
      logic high;
      logic mid;
      logic low;
   } relay_type;

   typedef struct packed {
      phase_type phase;
      logic [STEPS_WIDTH-1:0] ramp_index;
      logic [1:0] target_mode;
      logic [1:0] current_mode;
      relay_type relays;
   } seq_state_type;

endpackage

[rtl/frms_csr.sv]
module frms_csr #(
   parameter int TIMER_WIDTH = frms_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [frms_pkg::CFG_WIDTH-1:0] csr_data,
   output logic [TIMER_WIDTH-1:0] power_cycle_load,
   output logic [TIMER_WIDTH-1:0] settle_load,
   output logic [TIMER_WIDTH-1:0] prespin_load,
   output logic [frms_pkg::STEPS_WIDTH-1:0] ramp_steps
);

   localparam int CW = frms_pkg::CFG_WIDTH;
   localparam logic [CW-1:0] MAX_LOAD = (TIMER_WIDTH >= CW) ? {CW{1'b1}} :
      CW'((64'd1 << TIMER_WIDTH) - 64'd1);

   // timer values are stored already clipped to the counter width
   function automatic logic [TIMER_WIDTH-1:0] clip(input logic [CW-1:0] v);
      return (v > MAX_LOAD) ? {TIMER_WIDTH{1'b1}} : TIMER_WIDTH'(v);
   endfunction

   logic [TIMER_WIDTH-1:0] power_cycle_ff, power_cycle_in;
   logic [TIMER_WIDTH-1:0] settle_ff, settle_in;
   logic [TIMER_WIDTH-1:0] prespin_ff, prespin_in;
   logic [frms_pkg::STEPS_WIDTH-1:0] ramp_steps_ff, ramp_steps_in;
   logic wr;

   assign csr_ready = 1'b1;
   assign wr = csr_valid && csr_ready;

   always_comb begin
      power_cycle_in = power_cycle_ff;
      settle_in = settle_ff;
      prespin_in = prespin_ff;
      ramp_steps_in = ramp_steps_ff;
      if (wr) begin
         case (frms_pkg::csr_index_type'(csr_index))
            frms_pkg::CSR_POWER_CYCLE: power_cycle_in = clip(csr_data);
            frms_pkg::CSR_SETTLE: settle_in = clip(csr_data);
            frms_pkg::CSR_PRESPIN: prespin_in = clip(csr_data);
            frms_pkg::CSR_RAMP_STEPS: ramp_steps_in = csr_data[frms_pkg::STEPS_WIDTH-1:0];
            default: ramp_steps_in = ramp_steps_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_cycle_ff <= clip(frms_pkg::POWER_CYCLE_RESET);
         settle_ff <= clip(frms_pkg::SETTLE_RESET);
         prespin_ff <= clip(frms_pkg::PRESPIN_RESET);
         ramp_steps_ff <= frms_pkg::RAMP_STEPS_RESET;
      end else begin
         power_cycle_ff <= power_cycle_in;
         settle_ff <= settle_in;
         prespin_ff <= prespin_in;
         ramp_steps_ff <= ramp_steps_in;
      end
   end

   assign power_cycle_load = power_cycle_ff;
   assign settle_load = settle_ff;
   assign prespin_load = prespin_ff;
   assign ramp_steps = ramp_steps_ff;

endmodule

[rtl/frms_step.sv]
module frms_step #(
   parameter int TIMER_WIDTH = frms_pkg::TIMER_WIDTH_DEFAULT
) (
   input  frms_pkg::seq_state_type state_i,
   input  logic [TIMER_WIDTH-1:0] wait_i,
   input  logic [TIMER_WIDTH-1:0] settle_load,
   input  logic [TIMER_WIDTH-1:0] prespin_load,
   input  logic [frms_pkg::STEPS_WIDTH-1:0] ramp_steps,
   output frms_pkg::seq_state_type state_o,
   output logic [TIMER_WIDTH-1:0] wait_o
);

   logic [frms_pkg::STEPS_WIDTH-1:0] idx_next;
   logic done;

   always_comb begin
      state_o = state_i;
      wait_o = wait_i;
      idx_next = state_i.ramp_index + 1'b1;
      done = 1'b0;
      if (state_i.phase != frms_pkg::PH_IDLE && wait_i == '0) begin
         case (state_i.phase)
            frms_pkg::PH_CYCLE: begin
               state_o.relays.ext = 1'b1;
               state_o.phase = frms_pkg::PH_SETTLE;
               wait_o = settle_load;
            end
            frms_pkg::PH_SETTLE: begin
               case (frms_pkg::mode_type'(state_i.target_mode))
                  frms_pkg::MODE_LOW: begin
                     state_o.relays.low = 1'b1;
                     done = 1'b1;
                  end
                  frms_pkg::MODE_MID: begin
                     state_o.relays.mid = 1'b1;
                     done = 1'b1;
                  end
                  frms_pkg::MODE_HIGH: begin
                     state_o.relays.mid = 1'b1;
                     state_o.phase = frms_pkg::PH_PRESPIN;
                     wait_o = prespin_load;
                  end
                  default: done = 1'b1;
               endcase
            end
            frms_pkg::PH_PRESPIN: begin
               state_o.relays.mid = 1'b0;
               state_o.phase = frms_pkg::PH_SETTLE2;
               wait_o = settle_load;
            end
            frms_pkg::PH_SETTLE2: begin
               state_o.relays.high = 1'b1;
               if (ramp_steps == '0) begin
                  done = 1'b1;
               end else begin
                  state_o.ramp_index = frms_pkg::STEPS_WIDTH'(1);
                  state_o.phase = frms_pkg::PH_RAMP_ON;
                  wait_o = TIMER_WIDTH'(1);
               end
            end
            frms_pkg::PH_RAMP_ON: begin
               state_o.relays.high = 1'b0;
               state_o.phase = frms_pkg::PH_RAMP_OFF;
               wait_o = TIMER_WIDTH'(ramp_steps - state_i.ramp_index);
            end
            frms_pkg::PH_RAMP_OFF: begin
               state_o.relays.high = 1'b1;
               if (state_i.ramp_index >= ramp_steps) begin
                  done = 1'b1;
               end else begin
                  state_o.ramp_index = idx_next;
                  state_o.phase = frms_pkg::PH_RAMP_ON;
                  wait_o = TIMER_WIDTH'(idx_next);
               end
            end
            default: done = 1'b1;
         endcase
         if (done) begin
            state_o.current_mode = state_i.target_mode;
            state_o.phase = frms_pkg::PH_IDLE;
            wait_o = '0;
         end
      end
   end

endmodule

[rtl/fan_relay_mode_sequencer_top.sv]
// Fan relay mode sequencer. Each request beat (op 0 = 1 ms tick, op 1 = mode
// request) returns one response beat with the relay levels, the recorded mode,
// a busy flag and a refused-request flag; a new beat is accepted every cycle
// while the response register is free or being drained. The sequence state and
// the tick counter update in a single pass, including up to five zero-length
// waits in a row, so the rate is set by the response register alone. Waits longer
// than the TIMER_WIDTH counter are clipped to its largest value. The user must
// write configuration through the csr port only while idle; the block won't check.
module fan_relay_mode_sequencer_top #(
   parameter int TIMER_WIDTH = frms_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_op,
   input  logic [1:0] req_mode,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_relay_low_volt,
   output logic rsp_relay_mid_volt,
   output logic rsp_relay_high_volt,
   output logic rsp_relay_ext_supply,
   output logic [1:0] rsp_mode_now,
   output logic rsp_busy_res,
   output logic rsp_request_ignored,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [frms_pkg::CFG_WIDTH-1:0] csr_data
);

   localparam int CHAIN = frms_pkg::ZERO_WAIT_CHAIN;

   logic [TIMER_WIDTH-1:0] power_cycle_load, settle_load, prespin_load;
   logic [frms_pkg::STEPS_WIDTH-1:0] ramp_steps;

   frms_pkg::seq_state_type state_ff, state_in;
   logic [TIMER_WIDTH-1:0] wait_ff, wait_in;
   frms_pkg::seq_state_type chain_st [CHAIN+1];
   logic [TIMER_WIDTH-1:0] chain_wait [CHAIN+1];
   logic accept, ignored;

   logic rsp_valid_ff, rsp_valid_in;
   frms_pkg::relay_type rsp_relays_ff;
   logic [1:0] rsp_mode_ff;
   logic rsp_busy_ff, rsp_ignored_ff;

   frms_csr #(.TIMER_WIDTH(TIMER_WIDTH)) u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .power_cycle_load(power_cycle_load),
      .settle_load(settle_load),
      .prespin_load(prespin_load),
      .ramp_steps(ramp_steps)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;

   // first part of the beat: tick countdown or request start
   always_comb begin
      chain_st[0] = state_ff;
      chain_wait[0] = wait_ff;
      ignored = 1'b0;
      if (!req_op) begin
         if (state_ff.phase != frms_pkg::PH_IDLE && wait_ff != '0) begin
            chain_wait[0] = wait_ff - 1'b1;
         end
      end else if (state_ff.phase != frms_pkg::PH_IDLE || req_mode == state_ff.current_mode) begin
         ignored = 1'b1;
      end else begin
         chain_st[0].target_mode = req_mode;
         chain_st[0].ramp_index = '0;
         chain_st[0].relays.low = 1'b0;
         chain_st[0].relays.mid = 1'b0;
         chain_st[0].relays.high = 1'b0;
         chain_st[0].phase = frms_pkg::PH_SETTLE;
         chain_wait[0] = settle_load;
         if (frms_pkg::mode_type'(req_mode) == frms_pkg::MODE_OFF) begin
            chain_st[0].relays.ext = 1'b0;
         end else if (req_mode < state_ff.current_mode) begin
            chain_st[0].relays.ext = 1'b0;
            chain_st[0].phase = frms_pkg::PH_CYCLE;
            chain_wait[0] = power_cycle_load;
         end else begin
            chain_st[0].relays.ext = 1'b1;
         end
      end
   end

   // walk through expired waits
   for (genvar g = 0; g < CHAIN; g++) begin : g_chain
      frms_step #(.TIMER_WIDTH(TIMER_WIDTH)) u_step (
         .state_i(chain_st[g]),
         .wait_i(chain_wait[g]),
         .settle_load(settle_load),
         .prespin_load(prespin_load),
         .ramp_steps(ramp_steps),
         .state_o(chain_st[g+1]),
         .wait_o(chain_wait[g+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         state_in = chain_st[CHAIN];
         wait_in = chain_wait[CHAIN];
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= frms_pkg::PH_IDLE;
         state_ff.ramp_index <= '0;
         state_ff.target_mode <= '0;
         state_ff.current_mode <= '0;
         state_ff.relays <= '0;
         wait_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_relays_ff <= chain_st[CHAIN].relays;
         rsp_mode_ff <= chain_st[CHAIN].current_mode;
         rsp_busy_ff <= (chain_st[CHAIN].phase != frms_pkg::PH_IDLE);
         rsp_ignored_ff <= ignored;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_relay_low_volt = rsp_relays_ff.low;
   assign rsp_relay_mid_volt = rsp_relays_ff.mid;
   assign rsp_relay_high_volt = rsp_relays_ff.high;
   assign rsp_relay_ext_supply = rsp_relays_ff.ext;
   assign rsp_mode_now = rsp_mode_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_request_ignored = rsp_ignored_ff;

`ifndef SYNTHESIS
   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted beat produced no response");

   a_ignored_keeps_state: assert property (@(posedge clock) disable iff (reset)
      accept && ignored |=> state_ff == $past(state_ff) && wait_ff == $past(wait_ff))
      else $error("refused request changed the sequence state");

   a_idle_tick_keeps_state: assert property (@(posedge clock) disable iff (reset)
      accept && !req_op && state_ff.phase == frms_pkg::PH_IDLE |=> $stable(state_ff))
      else $error("tick while idle changed the sequence state");

   a_busy_low_open: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase != frms_pkg::PH_IDLE |-> !state_ff.relays.low)
      else $error("3.3V relay closed during a sequence");

   a_idle_wait_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == frms_pkg::PH_IDLE |-> wait_ff == '0)
      else $error("wait counter left loaded while idle");
`endif

endmodule

[tb/sv/fan_relay_mode_sequencer_top_tb.sv]
`timescale 1ns / 1ps

module fan_relay_mode_sequencer_top_tb;
   import frms_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int RANDOM_BEATS = 950;
   localparam int FINAL_BEATS = 250;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_REQUEST = 1'b1
   } beat_op_type;

   typedef enum logic [1:0] {
      ROW_BEAT,
      ROW_SETTINGS,
      ROW_DRAIN
   } row_kind_type;

   typedef struct packed {
      logic low;
      logic mid;
      logic high;
      logic ext;
      mode_type mode_now;
      logic busy;
      logic refused;
   } fan_status_type;

   typedef struct packed {
      logic [15:0] cycle_ms;
      logic [15:0] settle_ms;
      logic [15:0] prespin_ms;
      logic [5:0] steps;
   } fan_settings_type;

   typedef struct packed {
      row_kind_type kind;
      beat_op_type op;
      mode_type mode;
      logic typed;
      fan_status_type want;
      fan_settings_type cfg;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = OP_TICK;
   logic [1:0] req_mode = MODE_OFF;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_relay_low_volt;
   logic rsp_relay_mid_volt;
   logic rsp_relay_high_volt;
   logic rsp_relay_ext_supply;
   logic [1:0] rsp_mode_now;
   logic rsp_busy_res;
   logic rsp_request_ignored;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_POWER_CYCLE;
   logic [CFG_WIDTH-1:0] csr_data = '0;

   // sequencer shadow state
   fan_settings_type live_cfg = {POWER_CYCLE_RESET, SETTLE_RESET, PRESPIN_RESET,
                                 RAMP_STEPS_RESET};
   phase_type seq_phase = PH_IDLE;
   logic [15:0] ticks_left = '0;
   logic [5:0] step_idx = '0;
   mode_type goal_mode = MODE_OFF;
   mode_type fan_mode = MODE_OFF;
   relay_type relays = '0;

   fan_status_type status_q[$];
   stim_row_type plan[$];

   bit valid_up = 1'b0;
   int burst_left = 0;
   int quiet_cycles = 0;
   int fault_count = 0;
   int rsp_count = 0;
   int stall_pct = 0;
   int stall_hold = 0;
   int beat_total = 0;
   int request_total = 0;
   int refused_total = 0;
   int started_total = 0;
   int settings_total = 0;

   fan_relay_mode_sequencer_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_mode(req_mode),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_relay_low_volt(rsp_relay_low_volt),
      .rsp_relay_mid_volt(rsp_relay_mid_volt),
      .rsp_relay_high_volt(rsp_relay_high_volt),
      .rsp_relay_ext_supply(rsp_relay_ext_supply),
      .rsp_mode_now(rsp_mode_now),
      .rsp_busy_res(rsp_busy_res),
      .rsp_request_ignored(rsp_request_ignored),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic void begin_wait(phase_type ph, logic [15:0] n);
      seq_phase = ph;
      ticks_left = n;
   endfunction

   function automatic void finish_change();
      fan_mode = goal_mode;
      seq_phase = PH_IDLE;
      ticks_left = '0;
   endfunction

   function automatic void close_high_step();
      relays.high = 1'b1;
      begin_wait(PH_RAMP_ON, {10'd0, step_idx});
   endfunction

   function automatic void leave_phase();
      logic [5:0] rest;
      case (seq_phase)
         PH_CYCLE: begin
            relays.ext = 1'b1;
            begin_wait(PH_SETTLE, live_cfg.settle_ms);
         end
         PH_SETTLE: begin
            case (goal_mode)
               MODE_LOW: begin
                  relays.low = 1'b1;
                  finish_change();
               end
               MODE_MID: begin
                  relays.mid = 1'b1;
                  finish_change();
               end
               MODE_HIGH: begin
                  relays.mid = 1'b1;
                  begin_wait(PH_PRESPIN, live_cfg.prespin_ms);
               end
               default: finish_change();
            endcase
         end
         PH_PRESPIN: begin
            relays.mid = 1'b0;
            begin_wait(PH_SETTLE2, live_cfg.settle_ms);
         end
         PH_SETTLE2: begin
            if (live_cfg.steps == '0) begin
               relays.high = 1'b1;
               finish_change();
            end else begin
               step_idx = 6'd1;
               close_high_step();
            end
         end
         PH_RAMP_ON: begin
            relays.high = 1'b0;
            rest = live_cfg.steps - step_idx;
            begin_wait(PH_RAMP_OFF, {10'd0, rest});
         end
         PH_RAMP_OFF: begin
            if (step_idx >= live_cfg.steps) begin
               relays.high = 1'b1;
               finish_change();
            end else begin
               step_idx = step_idx + 6'd1;
               close_high_step();
            end
         end
         default: finish_change();
      endcase
   endfunction

   // zero-length waits fall through within the same beat
   function automatic void run_zero_waits();
      int guard;
      guard = 0;
      while (seq_phase != PH_IDLE && ticks_left == '0 && guard < 512) begin
         leave_phase();
         guard++;
      end
   endfunction

   function automatic fan_status_type apply_beat(beat_op_type op, mode_type md);
      fan_status_type s;
      s.refused = 1'b0;
      if (op == OP_TICK) begin
         if (seq_phase != PH_IDLE) begin
            if (ticks_left != '0) ticks_left = ticks_left - 16'd1;
            run_zero_waits();
         end
      end else if (seq_phase != PH_IDLE || md == fan_mode) begin
         s.refused = 1'b1;
      end else begin
         goal_mode = md;
         step_idx = '0;
         relays.low = 1'b0;
         relays.mid = 1'b0;
         relays.high = 1'b0;
         if (md == MODE_OFF) begin
            relays.ext = 1'b0;
            begin_wait(PH_SETTLE, live_cfg.settle_ms);
         end else if (md < fan_mode) begin
            relays.ext = 1'b0;
            begin_wait(PH_CYCLE, live_cfg.cycle_ms);
         end else begin
            relays.ext = 1'b1;
            begin_wait(PH_SETTLE, live_cfg.settle_ms);
         end
         run_zero_waits();
      end
      s.low = relays.low;
      s.mid = relays.mid;
      s.high = relays.high;
      s.ext = relays.ext;
      s.mode_now = fan_mode;
      s.busy = (seq_phase != PH_IDLE);
      return s;
   endfunction

   function automatic fan_status_type relay_status(logic lo, logic mi, logic hi, logic ex,
                                                   mode_type md, logic busy, logic refused);
      fan_status_type s;
      s = {lo, mi, hi, ex, md, busy, refused};
      return s;
   endfunction

   function automatic stim_row_type beat_row(beat_op_type op, mode_type md);
      stim_row_type r;
      r = '0;
      r.kind = ROW_BEAT;
      r.op = op;
      r.mode = md;
      return r;
   endfunction

   function automatic stim_row_type typed_row(beat_op_type op, mode_type md,
                                              fan_status_type want);
      stim_row_type r;
      r = beat_row(op, md);
      r.typed = 1'b1;
      r.want = want;
      return r;
   endfunction

   function automatic stim_row_type settings_row(fan_settings_type cfg);
      stim_row_type r;
      r = '0;
      r.kind = ROW_SETTINGS;
      r.cfg = cfg;
      return r;
   endfunction

   function automatic stim_row_type drain_row();
      stim_row_type r;
      r = '0;
      r.kind = ROW_DRAIN;
      return r;
   endfunction

   function automatic fan_settings_type random_settings();
      fan_settings_type c;
      c.cycle_ms = 16'($urandom_range(0, 8));
      c.settle_ms = 16'($urandom_range(0, 5));
      c.prespin_ms = 16'($urandom_range(0, 6));
      c.steps = 6'($urandom_range(1, 6));
      case ($urandom_range(0, 3))
         0: begin
            c.cycle_ms = '0;
            c.settle_ms = '0;
            c.prespin_ms = '0;
         end
         1: c.steps = 6'($urandom_range(7, 12));
         2: c.steps = '0;
         default: ;
      endcase
      return c;
   endfunction

   function automatic void note_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("mismatch: %s", msg);
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got)
         note_fault($sformatf("beat %0d %s expected %0d got %0d", rsp_count, name, want, got));
   endfunction

   task automatic send_beat(input beat_op_type op, input mode_type md, input bit typed = 1'b0,
                            input fan_status_type want = '0);
      fan_status_type seen;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0 && valid_up) begin
            req_valid <= 1'b0;
            valid_up = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_mode <= md;
      valid_up = 1'b1;
      do @(posedge clock); while (req_stall);
      seen = apply_beat(op, md);
      status_q.push_back(typed ? want : seen);
      burst_left--;
      beat_total++;
      if (op == OP_REQUEST) begin
         request_total++;
         if (seen.refused) refused_total++;
         else started_total++;
      end
   endtask

   task automatic send_tick();
      send_beat(OP_TICK, mode_type'($urandom_range(0, 3)));
   endtask

   task automatic run_until_idle();
      while (seq_phase != PH_IDLE) send_tick();
   endtask

   task automatic wait_all_results();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
         @(posedge clock);
      end
      while (status_q.size() != 0) @(posedge clock);
   endtask

   task automatic apply_settings(input fan_settings_type cfg);
      run_until_idle();
      wait_all_results();
      csr_valid <= 1'b1;
      for (int k = 0; k < 4; k++) begin
         csr_index_type idx;
         idx = csr_index_type'(k);
         csr_index <= idx;
         case (idx)
            CSR_POWER_CYCLE: csr_data <= cfg.cycle_ms;
            CSR_SETTLE: csr_data <= cfg.settle_ms;
            CSR_PRESPIN: csr_data <= cfg.prespin_ms;
            default: csr_data <= {10'd0, cfg.steps};
         endcase
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      live_cfg = cfg;
      settings_total++;
   endtask

   // response checker, receiver stall pattern and handshake activity
   always @(posedge clock) begin
      fan_status_type got;
      fan_status_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_relay_low_volt, rsp_relay_mid_volt, rsp_relay_high_volt,
                   rsp_relay_ext_supply, mode_type'(rsp_mode_now), rsp_busy_res,
                   rsp_request_ignored};
            if (status_q.size() == 0) begin
               note_fault($sformatf("beat %0d arrived with nothing pending", rsp_count));
            end else begin
               want = status_q.pop_front();
               check_field("relay_low_volt", want.low, got.low);
               check_field("relay_mid_volt", want.mid, got.mid);
               check_field("relay_high_volt", want.high, got.high);
               check_field("relay_ext_supply", want.ext, got.ext);
               check_field("mode_now", want.mode_now, got.mode_now);
               check_field("busy_res", want.busy, got.busy);
               check_field("request_ignored", want.refused, got.refused);
            end
            rsp_count++;
         end
      end
      if (stall_hold == 0) begin
         stall_hold = $urandom_range(20, 200);
         case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 25;
            3: stall_pct = 60;
            default: stall_pct = 90;
         endcase
      end
      stall_hold--;
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("no handshake for %0d cycles", QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int random_beats;
      int phase_len;
      int pick;

      // reset values, refusals, busy flag
      plan.push_back(typed_row(OP_TICK, MODE_OFF, relay_status(0, 0, 0, 0, MODE_OFF, 0, 0)));
      plan.push_back(typed_row(OP_REQUEST, MODE_OFF,
                               relay_status(0, 0, 0, 0, MODE_OFF, 0, 1)));
      plan.push_back(typed_row(OP_REQUEST, MODE_LOW,
                               relay_status(0, 0, 0, 1, MODE_OFF, 1, 0)));
      plan.push_back(typed_row(OP_REQUEST, MODE_MID,
                               relay_status(0, 0, 0, 1, MODE_OFF, 1, 1)));
      plan.push_back(typed_row(OP_REQUEST, MODE_HIGH,
                               relay_status(0, 0, 0, 1, MODE_OFF, 1, 1)));
      plan.push_back(beat_row(OP_TICK, MODE_HIGH));
      plan.push_back(drain_row());
      // all waits zero and no ramp: every change completes in one beat
      plan.push_back(settings_row({16'd0, 16'd0, 16'd0, 6'd0}));
      plan.push_back(typed_row(OP_REQUEST, MODE_HIGH,
                               relay_status(0, 0, 1, 1, MODE_HIGH, 0, 0)));
      plan.push_back(typed_row(OP_REQUEST, MODE_HIGH,
                               relay_status(0, 0, 1, 1, MODE_HIGH, 0, 1)));
      plan.push_back(typed_row(OP_TICK, MODE_LOW, relay_status(0, 0, 1, 1, MODE_HIGH, 0, 0)));
      plan.push_back(typed_row(OP_REQUEST, MODE_MID,
                               relay_status(0, 1, 0, 1, MODE_MID, 0, 0)));
      plan.push_back(typed_row(OP_REQUEST, MODE_OFF,
                               relay_status(0, 0, 0, 0, MODE_OFF, 0, 0)));
      plan.push_back(typed_row(OP_REQUEST, MODE_LOW,
                               relay_status(1, 0, 0, 1, MODE_LOW, 0, 0)));
      // single ramp step
      plan.push_back(settings_row({16'd0, 16'd0, 16'd0, 6'd1}));
      plan.push_back(typed_row(OP_REQUEST, MODE_HIGH,
                               relay_status(0, 0, 1, 1, MODE_LOW, 1, 0)));
      plan.push_back(beat_row(OP_TICK, MODE_MID));
      plan.push_back(settings_row({16'd3, 16'd2, 16'd2, 6'd3}));
      plan.push_back(beat_row(OP_REQUEST, MODE_LOW));
      plan.push_back(beat_row(OP_REQUEST, MODE_OFF));
      plan.push_back(beat_row(OP_TICK, MODE_OFF));
      plan.push_back(drain_row());
      plan.push_back(beat_row(OP_REQUEST, MODE_HIGH));
      plan.push_back(beat_row(OP_TICK, MODE_HIGH));
      plan.push_back(beat_row(OP_REQUEST, MODE_MID));
      plan.push_back(drain_row());
      plan.push_back(beat_row(OP_REQUEST, MODE_OFF));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_BEAT: send_beat(plan[i].op, plan[i].mode, plan[i].typed, plan[i].want);
            ROW_SETTINGS: apply_settings(plan[i].cfg);
            default: run_until_idle();
         endcase
      end

      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         apply_settings(random_settings());
         phase_len = $urandom_range(80, 160);
         for (int n = 0; n < phase_len; n++) begin
            pick = $urandom_range(0, 99);
            if (pick == 0) wait_all_results();
            if (seq_phase != PH_IDLE) begin
               if (pick < 90) send_tick();
               else send_beat(OP_REQUEST, mode_type'($urandom_range(0, 3)));
            end else if (pick < 70) begin
               send_beat(OP_REQUEST, mode_type'((fan_mode + $urandom_range(1, 3)) % 4));
            end else if (pick < 85) begin
               send_tick();
            end else begin
               send_beat(OP_REQUEST, fan_mode);
            end
         end
         random_beats += phase_len;
      end

      // widest settings, ending partway through a long soft start
      run_until_idle();
      if (fan_mode == MODE_HIGH) send_beat(OP_REQUEST, MODE_OFF);
      apply_settings({16'hFFFF, 16'd0, 16'd0, 6'd63});
      send_beat(OP_REQUEST, MODE_HIGH);
      for (int n = 0; n < FINAL_BEATS; n++) begin
         if ($urandom_range(0, 99) < 92) send_tick();
         else send_beat(OP_REQUEST, mode_type'($urandom_range(0, 3)));
      end

      wait_all_results();
      repeat (20) @(posedge clock);

      $display("%0d beats checked: %0d mode requests (%0d refused, %0d sequences started)",
               rsp_count, request_total, refused_total, started_total);
      $display("%0d register settings applied, zero waits through 63-step ramp",
               settings_total);
      if (fault_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/frms_pkg.sv
rtl/frms_csr.sv
rtl/frms_step.sv
rtl/fan_relay_mode_sequencer_top.sv
tb/sv/fan_relay_mode_sequencer_top_tb.sv
